// ----- design/ies_pkg.sv -----
// Shared types, effect codes and preset constants of the identify-effect sequencer.
package ies_pkg;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_IDENT  = 2'd2,
		KIND_DIRECT = 2'd3
	} kind_t;

	localparam logic [7:0] EFF_BLINK   = 8'd0;
	localparam logic [7:0] EFF_BREATHE = 8'd1;
	localparam logic [7:0] EFF_OKAY    = 8'd2;
	localparam logic [7:0] EFF_CHANNEL = 8'd11;
	localparam logic [7:0] EFF_FINISH  = 8'd254;
	localparam logic [7:0] EFF_STOP    = 8'd255;

	localparam logic [7:0] LVL_PEAK       = 8'd250;
	localparam logic [7:0] LVL_STEP       = 8'd50;
	localparam logic [7:0] LVL_IDENT      = 8'd159;
	localparam logic [7:0] COL_FULL       = 8'd255;
	localparam logic [7:0] COL_CHAN_GREEN = 8'd127;
	localparam logic [7:0] COL_CHAN_BLUE  = 8'd4;
	localparam logic [7:0] COL_IDENT_RED  = 8'd250;
	localparam logic [3:0] BREATHE_CYCLES = 4'd15;
	localparam logic [7:0] TICKS_SHORT    = 8'd10;
	localparam logic [7:0] TICKS_BREATHE  = 8'd200;
	localparam logic [7:0] TICKS_CHANNEL  = 8'd80;
	localparam logic [4:0] TIME_CLEAR     = 5'd0;
	localparam logic [4:0] TIME_STOP      = 5'd1;
	localparam logic [4:0] TIME_SHORT     = 5'd2;
	localparam logic [4:0] TIME_CHANNEL   = 5'd9;
	localparam logic [4:0] TIME_BREATHE   = 5'd17;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  effect_code;
		logic        on_in;
		logic [7:0]  level_in;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [15:0] identify_time_in;
	} item_t;

	typedef struct packed {
		logic       drive_valid;
		logic       drive_on;
		logic [7:0] drive_level;
		logic [7:0] drive_red;
		logic [7:0] drive_green;
		logic [7:0] drive_blue;
		logic       time_write_valid;
		logic [4:0] time_value;
		logic       effect_active;
	} result_t;

endpackage

// ----- design/ies_stream_if.sv -----
// Valid/ready stream interface carrying one request payload.
interface ies_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- design/ies_core.sv -----
// Effect state registers and the combinational step logic for one request.
module ies_core import ies_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  item_t   item,
	output result_t result
);

	typedef struct packed {
		logic [7:0] state;
		logic [7:0] level;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       ramp_up;
		logic       finish;
		logic [3:0] cycles;
		logic [7:0] ticks;
	} fx_t;

	fx_t fx_q;
	fx_t fx_d;

	function automatic result_t drive(input result_t r, input logic on, input logic [7:0] lvl,
			input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue);
		result_t o;
		o             = r;
		o.drive_valid = 1'b1;
		o.drive_on    = on;
		o.drive_level = on ? lvl : 8'd0;
		o.drive_red   = on ? red : 8'd0;
		o.drive_green = on ? green : 8'd0;
		o.drive_blue  = on ? blue : 8'd0;
		return o;
	endfunction

	function automatic result_t time_write(input result_t r, input logic [4:0] v);
		result_t o;
		o                  = r;
		o.time_write_valid = 1'b1;
		o.time_value       = v;
		return o;
	endfunction

	logic       active;
	logic [3:0] cycles_dec;

	assign active     = fx_q.state != EFF_STOP;
	assign cycles_dec = fx_q.cycles - 4'd1;

	always_comb begin
		fx_d   = fx_q;
		result = '0;
		case (item.kind)
			KIND_START: begin
				case (item.effect_code)
					EFF_BLINK: begin
						fx_d.state  = EFF_BLINK;
						fx_d.level  = LVL_PEAK;
						fx_d.red    = COL_FULL;
						fx_d.green  = 8'd0;
						fx_d.blue   = 8'd0;
						fx_d.finish = 1'b0;
						fx_d.ticks  = TICKS_SHORT;
						result      = time_write(result, TIME_SHORT);
					end
					EFF_BREATHE: begin
						fx_d.state   = EFF_BREATHE;
						fx_d.level   = 8'd0;
						fx_d.red     = item.red_in;
						fx_d.green   = item.green_in;
						fx_d.blue    = item.blue_in;
						fx_d.finish  = 1'b0;
						fx_d.ticks   = TICKS_BREATHE;
						fx_d.ramp_up = 1'b1;
						fx_d.cycles  = BREATHE_CYCLES;
						result       = time_write(result, TIME_BREATHE);
					end
					EFF_OKAY: begin
						fx_d.state  = EFF_OKAY;
						fx_d.level  = LVL_PEAK;
						fx_d.red    = 8'd0;
						fx_d.green  = COL_FULL;
						fx_d.blue   = 8'd0;
						fx_d.finish = 1'b0;
						fx_d.ticks  = TICKS_SHORT;
						result      = time_write(result, TIME_SHORT);
					end
					EFF_CHANNEL: begin
						fx_d.state  = EFF_CHANNEL;
						fx_d.level  = LVL_PEAK;
						fx_d.red    = COL_FULL;
						fx_d.green  = COL_CHAN_GREEN;
						fx_d.blue   = COL_CHAN_BLUE;
						fx_d.finish = 1'b0;
						fx_d.ticks  = TICKS_CHANNEL;
						result      = time_write(result, TIME_CHANNEL);
					end
					EFF_FINISH: begin
						if (active) begin
							fx_d.finish = 1'b1;
						end
					end
					EFF_STOP: begin
						fx_d.state = EFF_STOP;
						result     = time_write(result, TIME_STOP);
					end
					default: begin
					end
				endcase
			end
			KIND_TICK: begin
				if (active && fx_q.ticks != 8'd0) begin
					fx_d.ticks = fx_q.ticks - 8'd1;
					result = drive(result, 1'b1, fx_q.level, fx_q.red, fx_q.green, fx_q.blue);
					if (fx_q.state == EFF_BREATHE) begin
						if (fx_q.ramp_up) begin
							if (fx_q.level >= LVL_PEAK) begin
								fx_d.level   = fx_q.level - LVL_STEP;
								fx_d.ramp_up = 1'b0;
							end else begin
								fx_d.level = fx_q.level + LVL_STEP;
							end
						end else if (fx_q.level == 8'd0) begin
							fx_d.cycles = cycles_dec;
							if (cycles_dec != 4'd0 && !fx_q.finish) begin
								fx_d.level   = fx_q.level + LVL_STEP;
								fx_d.ramp_up = 1'b1;
							end else begin
								fx_d.ticks = 8'd0;
							end
						end else begin
							fx_d.level = fx_q.level - LVL_STEP;
						end
					end else if (fx_q.state != EFF_BLINK && fx_q.finish) begin
						fx_d.ticks = 8'd0;
					end
				end else if (active) begin
					fx_d.state   = EFF_STOP;
					fx_d.ramp_up = 1'b0;
					result = time_write(result, TIME_CLEAR);
					result = drive(result, item.on_in, item.level_in, item.red_in,
						item.green_in, item.blue_in);
				end
			end
			KIND_IDENT: begin
				if (!active) begin
					if (item.identify_time_in == 16'd0) begin
						result = drive(result, item.on_in, item.level_in, item.red_in,
							item.green_in, item.blue_in);
					end else begin
						result = drive(result, 1'b1, LVL_IDENT, COL_IDENT_RED, 8'd0, 8'd0);
					end
				end
			end
			KIND_DIRECT: begin
				result = drive(result, item.on_in, item.level_in, item.red_in,
					item.green_in, item.blue_in);
			end
			default: begin
			end
		endcase
		result.effect_active = fx_d.state != EFF_STOP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q <= '{EFF_STOP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 4'd0, 8'd0};
		end else if (step_en) begin
			fx_q <= fx_d;
		end
	end

endmodule

// ----- design/identify_effect_sequencer.sv -----
// Top level of the identify-effect sequencer: input register, step core, result register.
// A request passes from the input register through the step core into the result register.
// Accepts one request per cycle while the result side is ready; the input stage refills while a result is held.
// Each request yields exactly one result.
// Reset (arst_n low) empties both stages and returns the effect state to stop.
module identify_effect_sequencer import ies_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	ies_stream_if.sink   item,
	ies_stream_if.source result
);

	logic    valid_s1;
	item_t   item_s1;
	logic    result_valid_q;
	result_t result_q;
	result_t step_result;
	logic    advance;

	assign advance     = valid_s1 && (!result_valid_q || result.ready);
	assign item.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
	end

	ies_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.result  (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_result;
		end
	end

	assign result.valid   = result_valid_q;
	assign result.payload = result_q;

endmodule

// ----- design/ies_checker.sv -----
// Port-level checks of the identify-effect sequencer, bound to the top level.
module ies_checker import ies_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result request changed while stalled");

	a_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.drive_valid |-> !res.drive_on && res.drive_level == 8'd0
			&& res.drive_red == 8'd0 && res.drive_green == 8'd0 && res.drive_blue == 8'd0)
		else $error("drive fields set without a drive command");

	a_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.time_write_valid |-> res.time_value == TIME_CLEAR)
		else $error("time value set without a time write");

	a_stop_time: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.time_write_valid |->
			((res.time_value == TIME_CLEAR || res.time_value == TIME_STOP)
				== !res.effect_active))
		else $error("identify time disagrees with effect activity");

endmodule

bind identify_effect_sequencer ies_checker u_ies_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res       (result.payload)
);

// ----- tb/sv/lamp_effect_checker.sv -----
// Checker for the identify-effect sequencer: lamp effect prediction and result comparison.
module lamp_effect_checker import ies_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item_data,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result_data,
	output int      failures,
	output int      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] eff_mode;
	logic [7:0] eff_level;
	logic [7:0] eff_red;
	logic [7:0] eff_green;
	logic [7:0] eff_blue;
	logic       ramping_up;
	logic       finish_pending;
	logic [3:0] breaths_left;
	logic [7:0] tick_budget;

	result_t expected_drives[$];
	int      mismatches;

	assign failures = mismatches;

	function automatic result_t drive_cmd(result_t r, logic on, logic [7:0] lvl,
			logic [7:0] red, logic [7:0] grn, logic [7:0] blu);
		r.drive_valid = 1'b1;
		r.drive_on    = on;
		if (on) begin
			r.drive_level = lvl;
			r.drive_red   = red;
			r.drive_green = grn;
			r.drive_blue  = blu;
		end else begin
			r.drive_level = '0;
			r.drive_red   = '0;
			r.drive_green = '0;
			r.drive_blue  = '0;
		end
		return r;
	endfunction

	function automatic void load_effect(logic [7:0] code, logic [7:0] lvl, logic [7:0] red,
			logic [7:0] grn, logic [7:0] blu, logic [7:0] ticks);
		eff_mode       = code;
		eff_level      = lvl;
		eff_red        = red;
		eff_green      = grn;
		eff_blue       = blu;
		finish_pending = 1'b0;
		tick_budget    = ticks;
	endfunction

	function automatic result_t predict_lamp(item_t it);
		result_t r;
		r = '0;
		case (it.kind)
			KIND_START: begin
				case (it.effect_code)
					EFF_BLINK: begin
						load_effect(EFF_BLINK, LVL_PEAK, COL_FULL, 8'd0, 8'd0, TICKS_SHORT);
						r.time_write_valid = 1'b1;
						r.time_value       = TIME_SHORT;
					end
					EFF_BREATHE: begin
						load_effect(EFF_BREATHE, 8'd0, it.red_in, it.green_in, it.blue_in,
							TICKS_BREATHE);
						ramping_up         = 1'b1;
						breaths_left       = BREATHE_CYCLES;
						r.time_write_valid = 1'b1;
						r.time_value       = TIME_BREATHE;
					end
					EFF_OKAY: begin
						load_effect(EFF_OKAY, LVL_PEAK, 8'd0, COL_FULL, 8'd0, TICKS_SHORT);
						r.time_write_valid = 1'b1;
						r.time_value       = TIME_SHORT;
					end
					EFF_CHANNEL: begin
						load_effect(EFF_CHANNEL, LVL_PEAK, COL_FULL, COL_CHAN_GREEN,
							COL_CHAN_BLUE, TICKS_CHANNEL);
						r.time_write_valid = 1'b1;
						r.time_value       = TIME_CHANNEL;
					end
					EFF_FINISH: begin
						if (eff_mode != EFF_STOP) finish_pending = 1'b1;
					end
					EFF_STOP: begin
						eff_mode           = EFF_STOP;
						r.time_write_valid = 1'b1;
						r.time_value       = TIME_STOP;
					end
					default: ;
				endcase
			end
			KIND_TICK: begin
				if (eff_mode != EFF_STOP) begin
					if (tick_budget != 8'd0) begin
						tick_budget = tick_budget - 8'd1;
						r = drive_cmd(r, 1'b1, eff_level, eff_red, eff_green, eff_blue);
						if (eff_mode == EFF_BREATHE) begin
							if (ramping_up) begin
								if (eff_level >= LVL_PEAK) begin
									eff_level  = eff_level - LVL_STEP;
									ramping_up = 1'b0;
								end else begin
									eff_level = eff_level + LVL_STEP;
								end
							end else if (eff_level == 8'd0) begin
								breaths_left = breaths_left - 4'd1;
								if (breaths_left != 4'd0 && !finish_pending) begin
									eff_level  = eff_level + LVL_STEP;
									ramping_up = 1'b1;
								end else begin
									tick_budget = 8'd0;
								end
							end else begin
								eff_level = eff_level - LVL_STEP;
							end
						end else if (eff_mode != EFF_BLINK && finish_pending) begin
							tick_budget = 8'd0;
						end
					end else begin
						eff_mode           = EFF_STOP;
						ramping_up         = 1'b0;
						r.time_write_valid = 1'b1;
						r.time_value       = TIME_CLEAR;
						r = drive_cmd(r, it.on_in, it.level_in, it.red_in, it.green_in,
							it.blue_in);
					end
				end
			end
			KIND_IDENT: begin
				if (eff_mode == EFF_STOP) begin
					if (it.identify_time_in == 16'd0)
						r = drive_cmd(r, it.on_in, it.level_in, it.red_in, it.green_in,
							it.blue_in);
					else
						r = drive_cmd(r, 1'b1, LVL_IDENT, COL_IDENT_RED, 8'd0, 8'd0);
				end
			end
			default: begin
				r = drive_cmd(r, it.on_in, it.level_in, it.red_in, it.green_in, it.blue_in);
			end
		endcase
		r.effect_active = (eff_mode != EFF_STOP);
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			eff_mode       = EFF_STOP;
			eff_level      = '0;
			eff_red        = '0;
			eff_green      = '0;
			eff_blue       = '0;
			ramping_up     = 1'b0;
			finish_pending = 1'b0;
			breaths_left   = '0;
			tick_budget    = '0;
			expected_drives.delete();
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_drives.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = expected_drives.pop_front();
					check_field("drive_valid", want.drive_valid, result_data.drive_valid);
					check_field("drive_on", want.drive_on, result_data.drive_on);
					check_field("drive_level", want.drive_level, result_data.drive_level);
					check_field("drive_red", want.drive_red, result_data.drive_red);
					check_field("drive_green", want.drive_green, result_data.drive_green);
					check_field("drive_blue", want.drive_blue, result_data.drive_blue);
					check_field("time_write_valid", want.time_write_valid,
						result_data.time_write_valid);
					check_field("time_value", want.time_value, result_data.time_value);
					check_field("effect_active", want.effect_active,
						result_data.effect_active);
				end
			end
			if (item_valid && item_ready)
				expected_drives.push_back(predict_lamp(item_data));
			pending <= expected_drives.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the identify-effect sequencer: clock, reset, request stimulus and verdict.
module tb_top import ies_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BREATHE_RUN = 154;
	localparam int RANDOM_UNTIL = 460;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_SQUARE,
		RX_SPARSE
	} rx_mode_t;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   requests_sent;
	int   sequences_run;
	int   noise_runs;
	int   burst_left;

	rx_mode_t rx_mode;
	int       rx_hold;
	int       rx_phase;

	ies_stream_if #(.payload_t(item_t))   item_ch ();
	ies_stream_if #(.payload_t(result_t)) result_ch ();

	identify_effect_sequencer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	lamp_effect_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_ch.valid),
		.item_ready   (item_ch.ready),
		.item_data    (item_ch.payload),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.payload),
		.failures     (failures),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		result_ch.ready <= 1'b0;
		rx_hold  = 0;
		rx_phase = 0;
		rx_mode  = RX_OPEN;
		forever @(posedge clk) begin
			if (rx_hold == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_hold = $urandom_range(20, 80);
			end
			rx_hold--;
			rx_phase++;
			case (rx_mode)
				RX_OPEN:   result_ch.ready <= 1'b1;
				RX_RANDOM: result_ch.ready <= ($urandom_range(0, 9) < 7);
				RX_SQUARE: result_ch.ready <= rx_phase[2];
				default:   result_ch.ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	function automatic logic [7:0] known_effect(int idx);
		case (idx)
			0:       return EFF_BLINK;
			1:       return EFF_BREATHE;
			2:       return EFF_OKAY;
			3:       return EFF_CHANNEL;
			4:       return EFF_FINISH;
			default: return EFF_STOP;
		endcase
	endfunction

	function automatic item_t make_request(kind_t k, logic [7:0] code);
		item_t req;
		req.kind             = k;
		req.effect_code      = code;
		req.on_in            = 1'($urandom_range(0, 1));
		req.level_in         = 8'($urandom);
		req.red_in           = 8'($urandom);
		req.green_in         = 8'($urandom);
		req.blue_in          = 8'($urandom);
		req.identify_time_in = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
		return req;
	endfunction

	function automatic item_t random_request();
		logic [7:0] code;
		code = ($urandom_range(0, 1) == 0) ? known_effect($urandom_range(0, 5)) : 8'($urandom);
		return make_request(kind_t'($urandom_range(0, 3)), code);
	endfunction

	task automatic offer_request(input item_t req);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item_ch.valid   <= 1'b1;
		item_ch.payload <= req;
		do @(posedge clk); while (!item_ch.ready);
		burst_left--;
		requests_sent++;
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic run_effect(input logic [7:0] code);
		int ticks;
		int finish_at;
		int i;
		ticks     = (code == EFF_BREATHE) ? BREATHE_RUN
			: (code == EFF_CHANNEL) ? int'(TICKS_CHANNEL) + 2 : int'(TICKS_SHORT) + 2;
		finish_at = -1;
		if (code == EFF_BREATHE && $urandom_range(0, 7) != 0)
			finish_at = $urandom_range(0, 40);
		else if (code != EFF_BREATHE && $urandom_range(0, 1) == 0)
			finish_at = $urandom_range(0, ticks - 3);
		offer_request(make_request(KIND_START, code));
		i = 0;
		while (i < ticks) begin
			if (i == finish_at) begin
				offer_request(make_request(KIND_START, EFF_FINISH));
				if (ticks > i + 13) ticks = i + 13;
			end
			if ($urandom_range(0, 39) == 0)
				offer_request(random_request());
			else if ($urandom_range(0, 11) == 0)
				offer_request(make_request(kind_t'($urandom_range(2, 3)), 8'($urandom)));
			offer_request(make_request(KIND_TICK, 8'($urandom)));
			i++;
		end
		sequences_run++;
	endtask

	initial begin
		item_t req;
		int    n;
		arst_n          = 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.payload <= '0;
		requests_sent   = 0;
		sequences_run   = 0;
		noise_runs      = 0;
		burst_left      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		req = make_request(KIND_IDENT, 8'h00);
		req.on_in = 1'b0;
		req.identify_time_in = 16'd0;
		offer_request(req);
		req.identify_time_in = 16'hFFFF;
		offer_request(req);
		req = make_request(KIND_DIRECT, 8'hFF);
		{req.on_in, req.level_in, req.red_in, req.green_in, req.blue_in} = '1;
		offer_request(req);
		req.on_in = 1'b0;
		offer_request(req);
		req.on_in = 1'b1;
		{req.level_in, req.red_in, req.green_in, req.blue_in} = '0;
		offer_request(req);
		offer_request(make_request(KIND_TICK, 8'h00));
		offer_request(make_request(KIND_START, EFF_FINISH));
		offer_request(make_request(KIND_START, 8'd200));
		offer_request(make_request(KIND_START, EFF_STOP));
		offer_request(make_request(KIND_START, EFF_BLINK));
		offer_request(make_request(KIND_START, EFF_FINISH));
		offer_request(make_request(KIND_TICK, 8'h00));
		offer_request(make_request(KIND_TICK, 8'h00));
		offer_request(make_request(KIND_START, EFF_OKAY));
		offer_request(make_request(KIND_START, EFF_FINISH));
		offer_request(make_request(KIND_TICK, 8'h00));
		req = make_request(KIND_TICK, 8'h00);
		req.on_in = 1'b1;
		offer_request(req);
		offer_request(make_request(KIND_START, EFF_CHANNEL));
		req = make_request(KIND_IDENT, 8'h00);
		req.identify_time_in = 16'h8001;
		offer_request(req);
		offer_request(make_request(KIND_DIRECT, 8'h00));
		offer_request(make_request(KIND_START, EFF_STOP));
		req = make_request(KIND_START, EFF_BREATHE);
		{req.red_in, req.green_in, req.blue_in} = {8'hFF, 8'h00, 8'hFF};
		offer_request(req);
		offer_request(make_request(KIND_TICK, 8'h00));
		offer_request(make_request(KIND_TICK, 8'h00));
		offer_request(make_request(KIND_START, EFF_STOP));
		wait_drained();

		while (requests_sent < RANDOM_UNTIL) begin
			if ($urandom_range(0, 9) < 7) begin
				run_effect(known_effect($urandom_range(0, 3)));
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) offer_request(random_request());
				noise_runs++;
			end
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (4) @(posedge clk);
		$display("Sent %0d requests: directed corner cases, %0d effect runs with ticks,",
			requests_sent, sequences_run);
		$display("finish and interleaved updates, and %0d bursts of unconstrained requests.",
			noise_runs);
		if (failures == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
design/ies_pkg.sv
design/ies_stream_if.sv
design/ies_core.sv
design/identify_effect_sequencer.sv
design/ies_checker.sv
tb/sv/lamp_effect_checker.sv
tb/sv/tb_top.sv
